FILE: rtl/psch_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Request and result types, status codes, controller states and defaults.
// ----------------------------------------------------------------------------
package psch_pkg;

	localparam int unsigned DEFAULT_JOB_SLOTS = 8;

	localparam logic [1:0] ST_RAN    = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOADED = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  job_id;
		logic [15:0] arrival_time;
		logic [7:0]  burst_length;
		logic [7:0]  job_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  run_id;
		logic [15:0] tick_time;
		logic        finished;
		logic [15:0] completion_time;
		logic [15:0] turnaround;
		logic [15:0] waiting;
	} rsp_t;

	// Best ready job seen so far, passed from cell to cell during a scan.
	typedef struct packed {
		logic        valid;
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [7:0]  ident;
		logic [7:0]  burst;
		logic [7:0]  left;
	} cand_t;

	// Slot update issued to the cells when a request finishes.
	typedef struct packed {
		logic wr_en;
		logic run_en;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} sched_state_t;

endpackage

FILE: rtl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------
//  request | req_valid / req_ready | req (psch_pkg::req_t)
//  result  | rsp_valid / rsp_ready | rsp (psch_pkg::rsp_t)
//
// A load request goes from accept straight to the finish state, which writes
// the result register once it is free. A tick request first scans: the candidate
// record must ripple through the whole row of slot cells, one cell per cycle.
// A new request is accepted only in the idle state, after the last one finishes.
// One request is in flight at a time; the result register frees the request
// side, so a new request is accepted while a result waits for rsp_ready.
// Reset clears the clock, the entry count and every slot's done flag.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
	parameter int unsigned JOB_SLOTS = psch_pkg::DEFAULT_JOB_SLOTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  psch_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output psch_pkg::rsp_t rsp
);
	import psch_pkg::*;

	localparam int unsigned IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(JOB_SLOTS + 1);

	sched_state_t state_q, state_d;
	logic [IDX_W-1:0] scan_cnt_q;
	logic [CNT_W-1:0] entry_cnt_q;
	logic [15:0]      clock_q;
	req_t             req_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	logic req_fire;
	logic finish_fire;
	logic full;
	logic load_ok;
	logic tick_run;

	cand_t            cand_w [JOB_SLOTS+1];
	logic [IDX_W-1:0] idx_w  [JOB_SLOTS+1];
	cand_t            win;
	logic [15:0]      completion;
	logic [15:0]      tat;

	assign req_fire = req_valid && req_ready;
	assign full     = (entry_cnt_q == CNT_W'(JOB_SLOTS));
	assign win      = cand_w[JOB_SLOTS];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = (req.mode == MODE_TICK) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (scan_cnt_q == IDX_W'(JOB_SLOTS - 1)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (finish_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		req_ready   = 1'b0;
		finish_fire = 1'b0;
		case (state_q)
			S_IDLE:   req_ready   = 1'b1;
			S_SCAN:   req_ready   = 1'b0;
			S_FINISH: finish_fire = !rsp_valid_q || rsp_ready;
			default: begin
				req_ready   = 1'b0;
				finish_fire = 1'b0;
			end
		endcase
	end

	assign load_ok  = finish_fire && (req_q.mode == MODE_LOAD) && !full;
	assign tick_run = finish_fire && (req_q.mode == MODE_TICK) && win.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_cnt_q  <= '0;
			entry_cnt_q <= '0;
			clock_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end else begin
				scan_cnt_q <= '0;
			end
			if (load_ok) begin
				entry_cnt_q <= entry_cnt_q + CNT_W'(1);
			end
			if (finish_fire && (req_q.mode == MODE_TICK)) begin
				clock_q <= clock_q + 16'd1;
			end
			if (finish_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (finish_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign completion = clock_q + 16'd1;
	assign tat        = completion - win.arrival;

	always_comb begin
		rsp_d = '0;
		if (req_q.mode == MODE_LOAD) begin
			rsp_d.status = full ? ST_FULL : ST_LOADED;
		end else begin
			rsp_d.tick_time = clock_q;
			if (!win.valid) begin
				rsp_d.status = ST_IDLE;
			end else begin
				rsp_d.status = ST_RAN;
				rsp_d.run_id = win.ident;
				if (win.left <= 8'd1) begin
					rsp_d.finished        = 1'b1;
					rsp_d.completion_time = completion;
					rsp_d.turnaround      = tat;
					rsp_d.waiting         = tat - {8'd0, win.burst};
				end
			end
		end
	end

	assign cand_w[0] = '0;
	assign idx_w[0]  = '0;

	for (genvar i = 0; i < JOB_SLOTS; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.wr_en  = load_ok && (entry_cnt_q == CNT_W'(i));
		assign ctl.run_en = tick_run;

		psch_cell #(
			.IDX_W      (IDX_W),
			.CELL_INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.run_idx   (idx_w[JOB_SLOTS]),
			.load      (req_q),
			.used      (CNT_W'(i) < entry_cnt_q),
			.clock_now (clock_q),
			.cand_in   (cand_w[i]),
			.idx_in    (idx_w[i]),
			.cand_out  (cand_w[i+1]),
			.idx_out   (idx_w[i+1])
		);
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(JOB_SLOTS))
		else $error("entry count beyond table size");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("result raised outside finish");

	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		(finish_fire && req_q.mode == MODE_TICK) |=> clock_q == $past(clock_q) + 16'd1)
		else $error("clock did not advance on tick");

	a_completion: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.finished) |->
			(rsp_q.status == ST_RAN && rsp_q.completion_time == rsp_q.tick_time + 16'd1))
		else $error("bad completion time");

	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> (state_q == S_SCAN || state_q == S_FINISH))
		else $error("scan left early");

endmodule

FILE: rtl/psch_cell.sv
// ----------------------------------------------------------------------------
// Scheduler slot cell
// Holds one job entry and merges it into the best-candidate record that
// travels down the row, registering the merged record every cycle.
// ----------------------------------------------------------------------------
module psch_cell #(
	parameter int unsigned IDX_W      = 3,
	parameter int unsigned CELL_INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  psch_pkg::cell_ctl_t ctl,
	input  logic [IDX_W-1:0]  run_idx,
	input  psch_pkg::req_t    load,
	input  logic              used,
	input  logic [15:0]       clock_now,
	input  psch_pkg::cand_t   cand_in,
	input  logic [IDX_W-1:0]  idx_in,
	output psch_pkg::cand_t   cand_out,
	output logic [IDX_W-1:0]  idx_out
);
	import psch_pkg::*;

	logic        done_q;
	logic [15:0] arr_q;
	logic [7:0]  burst_q;
	logic [7:0]  left_q;
	logic [7:0]  prio_q;
	logic [7:0]  ident_q;
	cand_t       cand_q;
	logic [IDX_W-1:0] idx_q;

	logic ready;
	logic take;
	logic hit;

	assign ready = used && !done_q && (arr_q <= clock_now);
	assign take  = ready && (!cand_in.valid || (prio_q > cand_in.prio) ||
		((prio_q == cand_in.prio) && (arr_q < cand_in.arrival)));
	assign hit   = ctl.run_en && (run_idx == IDX_W'(CELL_INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (ctl.wr_en) begin
			done_q <= 1'b0;
		end else if (hit && (left_q <= 8'd1)) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			ident_q <= load.job_id;
			arr_q   <= load.arrival_time;
			burst_q <= load.burst_length;
			left_q  <= load.burst_length;
			prio_q  <= load.job_priority;
		end else if (hit) begin
			// saturate at zero
			left_q <= (left_q <= 8'd1) ? 8'd0 : left_q - 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cand_q <= '{valid: 1'b1, prio: prio_q, arrival: arr_q, ident: ident_q,
				burst: burst_q, left: left_q};
			idx_q  <= IDX_W'(CELL_INDEX);
		end else begin
			cand_q <= cand_in;
			idx_q  <= idx_in;
		end
	end

	assign cand_out = cand_q;
	assign idx_out  = idx_q;

endmodule
